/* design/assert_macros.svh */
// Assertion macros used by the top-level design file.
// Both macros expect a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent is checked in the same cycle as the antecedent.
`define PSTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent is checked in the cycle after the antecedent.
`define PSTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PSTS_ASSERT_IMP(lbl, ante, cons)
`define PSTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/psts_pkg.sv */
package psts_pkg;

    // Command codes.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_DRAW   = 2'd2;

    // Register indexes.
    localparam logic [2:0] CFG_FIELD_W  = 3'd0;
    localparam logic [2:0] CFG_FIELD_H  = 3'd1;
    localparam logic [2:0] CFG_SCREEN_W = 3'd2;
    localparam logic [2:0] CFG_SCREEN_H = 3'd3;
    localparam logic [2:0] CFG_INTERP   = 3'd4;

    // Fixed widths and constants.
    localparam int POS_W = 20;
    localparam int OLD_W = 22;
    localparam int DIV_W = 21;
    localparam int CNT_W = 5;
    localparam logic [8:0]  FRAME_ONE  = 9'd256;
    localparam logic [12:0] SCREEN_MAX = 13'd4096;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         star;
        logic [19:0]        load_x;
        logic [19:0]        load_y;
        logic [7:0]         load_shade;
        logic signed [19:0] delta_x;
        logic signed [19:0] delta_y;
        logic [8:0]         frame;
    } t_in_item;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  intensity;
        logic        last;
    } t_out_item;

    // One table entry.
    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [OLD_W-1:0] old_x;
        logic [OLD_W-1:0] old_y;
        logic [7:0]       shade;
    } t_star;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [POS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_DIV,
        S_FIX,
        S_WRITE,
        S_BLEND,
        S_PREP,
        S_EMIT
    } t_state;

endpackage

/* design/psts_div.sv */
module psts_div
    import psts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_dvd, n_dvd;
    logic [POS_W-1:0] r_dsr;
    logic [POS_W:0]   trial;
    logic             fits;

    // One restoring step: bring in the next dividend bit and subtract if it fits.
    assign trial = {r_rem, r_dvd[DIV_W-1]};
    assign fits  = trial >= {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_req.dividend;
        end else if (r_busy) begin
            n_rem = fits ? POS_W'(trial - {1'b0, r_dsr}) : trial[POS_W-1:0];
            n_dvd = {r_dvd[DIV_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Operands need no reset.
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        if (i_req.start) begin
            r_dsr <= i_req.divisor;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

/* design/parallax_star_table_splat_top.sv */
// Parallax star table with anti-aliased pixel output.
// Input channel (i_in_valid / o_in_ready, payload i_in) takes one command item:
// load writes a star, update moves and wraps a star, draw emits its pixels.
// Output channel (o_out_valid / i_out_ready, payload o_out) carries one pixel
// item at a time; the final pixel of a draw has last set. A draw may emit none.
// Configuration channel (i_cfg_valid / o_cfg_ready) is always ready; write only
// while the block is idle.
// Per item: a load is written as it is accepted; an update moves the x axis and
// then the y axis, and each axis that wraps runs the shared divider for 21 steps
// between the multiply and the fix-up; a draw blends the old and new positions
// unless interpolation is off, then emits one pixel per cycle while the receiver
// keeps up. The shared multiplier, the bit-serial divider and the single table
// write port set this pace; o_in_ready is high only when idle.
// A finished pixel waits in the output register; while the receiver stalls
// the draw holds, and a new item is accepted once the last pixel is queued.
// Reset clears the control state and restores the register defaults; table
// entries hold no defined value until loaded.
module parallax_star_table_splat_top
    import psts_pkg::*;
#(
    parameter int STAR_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    localparam int IDX_W = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;

    // Configuration registers.
    logic [19:0] r_fw, r_fh;
    logic [12:0] r_sw, r_sh;
    logic        r_interp;

    // Control and working state.
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx;
    logic signed [19:0] r_dx, r_dy;
    logic [8:0]         r_f;
    logic               r_axis;
    logic [1:0]         r_step;
    logic signed [32:0] r_acc;
    logic signed [22:0] r_move;
    logic               r_neg;
    logic [POS_W-1:0]   r_newpos;
    logic signed [24:0] r_ix, r_iy;
    logic [11:0]        r_px0, r_py0;
    logic signed [8:0]  r_fx, r_fy;
    logic [3:0]         r_mask;
    logic               r_out_valid;
    t_out_item          r_out;
    t_star              r_rd;

    t_star              mem [STAR_COUNT];
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_star              mem_wdata;

    logic               in_acc, in_range;
    logic [IDX_W-1:0]   in_idx;
    logic [POS_W-1:0]   fw_eff, fh_eff, w_sel;
    logic [12:0]        sw_eff, sh_eff;

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic signed [22:0] mul_a;
    logic signed [9:0]  mul_b;
    logic signed [32:0] mul_p;

    // Handshake and item decode.
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign in_range    = {24'd0, i_in.star} < 32'(STAR_COUNT);
    assign in_idx      = IDX_W'(i_in.star);

    // Register values with their special cases applied.
    assign fw_eff = (r_fw == '0) ? POS_W'(1) : r_fw;
    assign fh_eff = (r_fh == '0) ? POS_W'(1) : r_fh;
    assign sw_eff = (r_sw > SCREEN_MAX) ? SCREEN_MAX : r_sw;
    assign sh_eff = (r_sh > SCREEN_MAX) ? SCREEN_MAX : r_sh;
    assign w_sel  = r_axis ? fh_eff : fw_eff;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw     <= 20'd266240;
            r_fh     <= 20'd172032;
            r_sw     <= 13'd800;
            r_sh     <= 13'd480;
            r_interp <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FIELD_W:  r_fw     <= i_cfg_data;
                CFG_FIELD_H:  r_fh     <= i_cfg_data;
                CFG_SCREEN_W: r_sw     <= i_cfg_data[12:0];
                CFG_SCREEN_H: r_sh     <= i_cfg_data[12:0];
                CFG_INTERP:   r_interp <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Shared multiplier operand selection.
    logic               emit_xc, emit_yc;
    logic [1:0]         emit_c;
    logic [9:0]         wx, wy;
    logic [10:0]        wsum;
    logic [8:0]         fx_abs, fy_abs;

    always_comb begin
        if (r_mask[0])      emit_c = 2'd0;
        else if (r_mask[1]) emit_c = 2'd1;
        else if (r_mask[2]) emit_c = 2'd2;
        else                emit_c = 2'd3;
        emit_xc = emit_c[1];
        emit_yc = emit_c[0];
        fx_abs  = r_fx[8] ? 9'(-r_fx) : r_fx;
        fy_abs  = r_fy[8] ? 9'(-r_fy) : r_fy;
        wx      = emit_xc ? 10'(10'sd256 - {r_fx[8], r_fx}) : {1'b0, fx_abs};
        wy      = emit_yc ? 10'(10'sd256 - {r_fy[8], r_fy}) : {1'b0, fy_abs};
        wsum    = {1'b0, wx} + {1'b0, wy};
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MOVE: begin
                mul_a = r_axis ? {{3{r_dy[19]}}, r_dy} : {{3{r_dx[19]}}, r_dx};
                mul_b = {2'b00, r_rd.shade};
            end
            S_BLEND: begin
                case (r_step)
                    2'd0: begin
                        mul_a = {r_rd.old_x[OLD_W-1], r_rd.old_x};
                        mul_b = {1'b0, 9'(FRAME_ONE - r_f)};
                    end
                    2'd1: begin
                        mul_a = {3'b000, r_rd.pos_x};
                        mul_b = {1'b0, r_f};
                    end
                    2'd2: begin
                        mul_a = {r_rd.old_y[OLD_W-1], r_rd.old_y};
                        mul_b = {1'b0, 9'(FRAME_ONE - r_f)};
                    end
                    default: begin
                        mul_a = {3'b000, r_rd.pos_y};
                        mul_b = {1'b0, r_f};
                    end
                endcase
            end
            S_EMIT: begin
                mul_a = {12'd0, wsum};
                mul_b = {2'b00, r_rd.shade};
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Move and wrap decision for the current axis.
    logic signed [32:0] move_fl;
    logic signed [22:0] move_v, n_pos;
    logic [POS_W-1:0]   cur_pos;
    logic               wrap_neg, wrap_pos;

    always_comb begin
        move_fl  = mul_p >>> 8;
        move_v   = r_axis ? move_fl[22:0] : 23'(-move_fl[22:0]);
        cur_pos  = r_axis ? r_rd.pos_y : r_rd.pos_x;
        n_pos    = $signed({3'b000, cur_pos}) + move_v;
        wrap_neg = n_pos[22];
        wrap_pos = !n_pos[22] && (n_pos > $signed({3'b000, w_sel}));
    end

    assign div_req.start    = (r_state == S_MOVE) && (wrap_neg || wrap_pos);
    assign div_req.dividend = wrap_neg ? DIV_W'(-n_pos) : DIV_W'(n_pos - 23'sd1);
    assign div_req.divisor  = w_sel;

    psts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Wrapped position from the remainder.
    logic [POS_W-1:0] div_pos;
    always_comb begin
        if (r_neg) begin
            div_pos = (div_rsp.rem == '0) ? '0 : POS_W'(w_sel - div_rsp.rem);
        end else begin
            div_pos = POS_W'(div_rsp.rem + 1'b1);
        end
    end

    // Blend result and split into integer pixel and signed fraction.
    logic signed [32:0] blend_sum;
    logic signed [24:0] ix_abs, iy_abs;
    logic signed [16:0] ipx, ipy;
    logic signed [17:0] ipx_w, ipy_w, sw_s, sh_s;
    logic               vx0, vx1, vy0, vy1;

    always_comb begin
        blend_sum = r_acc + mul_p;
        ix_abs    = r_ix[24] ? -r_ix : r_ix;
        iy_abs    = r_iy[24] ? -r_iy : r_iy;
        ipx       = r_ix[24] ? -$signed({1'b0, ix_abs[23:8]}) : $signed({1'b0, ix_abs[23:8]});
        ipy       = r_iy[24] ? -$signed({1'b0, iy_abs[23:8]}) : $signed({1'b0, iy_abs[23:8]});
        ipx_w     = {ipx[16], ipx};
        ipy_w     = {ipy[16], ipy};
        sw_s      = $signed({5'd0, sw_eff});
        sh_s      = $signed({5'd0, sh_eff});
        vx0       = !ipx_w[17] && (ipx_w < sw_s);
        vx1       = (ipx_w >= 18'sd1) && ((ipx_w - 18'sd1) < sw_s);
        vy0       = !ipy_w[17] && (ipy_w < sh_s);
        vy1       = (ipy_w >= 18'sd1) && ((ipy_w - 18'sd1) < sh_s);
    end

    // Pixel item for the current corner.
    logic      emit_fire;
    logic      emit_last;
    logic [32:0] inten_full;
    t_out_item emit_item;

    assign emit_fire  = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign emit_last  = ((r_mask & (r_mask - 4'd1)) == 4'd0);
    assign inten_full = mul_p >>> 9;

    always_comb begin
        emit_item.pixel_x   = emit_xc ? 12'(r_px0 - 12'd1) : r_px0;
        emit_item.pixel_y   = emit_yc ? 12'(r_py0 - 12'd1) : r_py0;
        emit_item.intensity = (inten_full > 33'sd255) ? 8'd255 : inten_full[7:0];
        emit_item.last      = emit_last;
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && in_range) begin
                    if (i_in.cmd == CMD_UPDATE)    n_state = S_MOVE;
                    else if (i_in.cmd == CMD_DRAW) n_state = S_BLEND;
                end
            end
            S_MOVE:  n_state = (wrap_neg || wrap_pos) ? S_DIV : S_FIX;
            S_DIV:   if (div_rsp.done) n_state = S_FIX;
            S_FIX:   n_state = r_axis ? S_WRITE : S_MOVE;
            S_WRITE: n_state = S_IDLE;
            S_BLEND: if (!r_interp || r_step == 2'd3) n_state = S_PREP;
            S_PREP:  n_state = ({vx1 & vy1, vx1 & vy0, vx0 & vy1, vx0 & vy0} != 4'd0) ?
                               S_EMIT : S_IDLE;
            S_EMIT:  if (emit_fire && emit_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_fire)        r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_idx  <= in_idx;
            r_dx   <= i_in.delta_x;
            r_dy   <= i_in.delta_y;
            r_f    <= (i_in.frame > FRAME_ONE) ? FRAME_ONE : i_in.frame;
            r_axis <= 1'b0;
            r_step <= 2'd0;
        end
        if (r_state == S_MOVE) begin
            r_move   <= move_v;
            r_neg    <= wrap_neg;
            r_newpos <= n_pos[POS_W-1:0];
        end
        if (r_state == S_DIV && div_rsp.done) begin
            r_newpos <= div_pos;
        end
        if (r_state == S_FIX) begin
            r_axis <= 1'b1;
        end
        if (r_state == S_BLEND) begin
            r_step <= r_step + 2'd1;
            if (!r_interp) begin
                r_ix <= $signed({5'd0, r_rd.pos_x});
                r_iy <= $signed({5'd0, r_rd.pos_y});
            end else begin
                case (r_step)
                    2'd0, 2'd2: r_acc <= mul_p;
                    2'd1:       r_ix  <= blend_sum[32:8];
                    default:    r_iy  <= blend_sum[32:8];
                endcase
            end
        end
        if (r_state == S_PREP) begin
            r_px0  <= ipx[11:0];
            r_py0  <= ipy[11:0];
            r_fx   <= r_ix[24] ? 9'(-$signed({1'b0, ix_abs[7:0]})) : {1'b0, ix_abs[7:0]};
            r_fy   <= r_iy[24] ? 9'(-$signed({1'b0, iy_abs[7:0]})) : {1'b0, iy_abs[7:0]};
            r_mask <= {vx1 & vy1, vx1 & vy0, vx0 & vy1, vx0 & vy0};
        end
        if (emit_fire) begin
            r_mask         <= r_mask & ~(4'd1 << emit_c);
            r_out          <= emit_item;
        end
    end

    // Star table: one write port, one registered read port.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_rd;
        if (in_acc && in_range && i_in.cmd == CMD_LOAD) begin
            mem_we          = 1'b1;
            mem_waddr       = in_idx;
            mem_wdata.pos_x = i_in.load_x;
            mem_wdata.pos_y = i_in.load_y;
            mem_wdata.old_x = {2'b00, i_in.load_x};
            mem_wdata.old_y = {2'b00, i_in.load_y};
            mem_wdata.shade = i_in.load_shade;
        end else if (r_state == S_WRITE) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Read on accept; an update then rewrites the entry copy axis by axis.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd <= mem[in_idx];
        end else if (r_state == S_FIX) begin
            if (r_axis) begin
                r_rd.pos_y <= r_newpos;
                r_rd.old_y <= OLD_W'({3'b000, r_newpos} - r_move);
            end else begin
                r_rd.pos_x <= r_newpos;
                r_rd.old_x <= OLD_W'({3'b000, r_newpos} - r_move);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`include "assert_macros.svh"

    `PSTS_ASSERT_IMP(a_emit_has_work, r_state == S_EMIT, r_mask != 4'd0)
    `PSTS_ASSERT_IMP(a_wrap_in_field, r_state == S_FIX, r_newpos <= w_sel)
    `PSTS_ASSERT_NEXT(a_load_single, in_acc && i_in.cmd == CMD_LOAD, r_state == S_IDLE)

endmodule

/* test/parallax_star_table_splat_top_test.sv */
`timescale 1ns / 100ps

module parallax_star_table_splat_top_test;
    import psts_pkg::*;

    localparam int  CLK_HALF    = 6;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  SETTLE      = 150;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in        = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data  = '0;

    parallax_star_table_splat_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted copy of the star table and the registers.
    logic [19:0] tbl_pos_x [256];
    logic [19:0] tbl_pos_y [256];
    logic [21:0] tbl_old_x [256];
    logic [21:0] tbl_old_y [256];
    logic [7:0]  tbl_shade [256];
    bit          tbl_loaded [256];
    logic [19:0] reg_field_w  = 20'd266240;
    logic [19:0] reg_field_h  = 20'd172032;
    logic [12:0] reg_screen_w = 13'd800;
    logic [12:0] reg_screen_h = 13'd480;
    logic        reg_interp   = 1'b1;

    t_out_item pixel_queue [$];
    int        fail_count  = 0;
    int        pixel_count = 0;
    int        item_count  = 0;
    int        cycle_count = 0;
    int        stall_left  = 0;
    bit        calm        = 1'b0;

    // Free-running clock.
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic longint floor_div256(longint v);
        return v >>> 8;
    endfunction

    // Moves one axis and folds it back into the field; the old position follows.
    function automatic void wrap_axis(ref logic [19:0] pos, ref logic [21:0] old,
                                      input longint move, input logic [19:0] size);
        longint w;
        longint n;
        longint o;
        longint k;
        w = (size == 0) ? 1 : longint'(size);
        n = longint'(pos) + move;
        o = longint'(pos);
        if (n < 0) begin
            k = (-n + w - 1) / w;
            n += k * w;
            o += k * w;
        end else if (n > w) begin
            k = (n - 1) / w;
            n -= k * w;
            o -= k * w;
        end
        old = o[21:0];
        pos = n[19:0];
    endfunction

    // Works out the pixels a draw produces and queues them.
    function automatic void predict_splat(logic [7:0] s, logic [8:0] frame_in);
        longint f;
        longint ix;
        longint iy;
        longint ipx;
        longint ipy;
        longint fx;
        longint fy;
        longint sw;
        longint sh;
        longint px;
        longint py;
        longint wsum;
        longint inten;
        longint dxw;
        longint dyw;
        int     n;
        t_out_item pix;
        f = (frame_in > 256) ? 256 : longint'(frame_in);
        if (reg_interp) begin
            ix = floor_div256(longint'($signed(tbl_old_x[s])) * (256 - f)
                              + longint'(tbl_pos_x[s]) * f);
            iy = floor_div256(longint'($signed(tbl_old_y[s])) * (256 - f)
                              + longint'(tbl_pos_y[s]) * f);
        end else begin
            ix = longint'(tbl_pos_x[s]);
            iy = longint'(tbl_pos_y[s]);
        end
        ipx = ix / 256;
        ipy = iy / 256;
        fx  = ix - ipx * 256;
        fy  = iy - ipy * 256;
        sw  = (reg_screen_w > 4096) ? 4096 : longint'(reg_screen_w);
        sh  = (reg_screen_h > 4096) ? 4096 : longint'(reg_screen_h);
        n   = 0;
        for (int xc = 0; xc <= 1; xc++) begin
            px = ipx - xc;
            if (px < 0 || px >= sw) continue;
            for (int yc = 0; yc <= 1; yc++) begin
                py = ipy - yc;
                if (py < 0 || py >= sh) continue;
                dxw = xc * 256 - fx;
                dyw = yc * 256 - fy;
                if (dxw < 0) dxw = -dxw;
                if (dyw < 0) dyw = -dyw;
                wsum  = dxw + dyw;
                inten = (wsum * longint'(tbl_shade[s])) / 512;
                if (inten > 255) inten = 255;
                pix.pixel_x   = px[11:0];
                pix.pixel_y   = py[11:0];
                pix.intensity = inten[7:0];
                pix.last      = 1'b0;
                pixel_queue.push_back(pix);
                n++;
            end
        end
        if (n > 0) pixel_queue[pixel_queue.size() - 1].last = 1'b1;
    endfunction

    // Applies one accepted command to the predicted table.
    function automatic void predict_command(t_in_item it);
        logic [7:0] s;
        s = it.star;
        case (it.cmd)
            CMD_LOAD: begin
                tbl_pos_x[s]  = it.load_x;
                tbl_pos_y[s]  = it.load_y;
                tbl_old_x[s]  = {2'b00, it.load_x};
                tbl_old_y[s]  = {2'b00, it.load_y};
                tbl_shade[s]  = it.load_shade;
                tbl_loaded[s] = 1'b1;
            end
            CMD_UPDATE: begin
                wrap_axis(tbl_pos_x[s], tbl_old_x[s],
                          -floor_div256(longint'(it.delta_x) * longint'(tbl_shade[s])),
                          reg_field_w);
                wrap_axis(tbl_pos_y[s], tbl_old_y[s],
                          floor_div256(longint'(it.delta_y) * longint'(tbl_shade[s])),
                          reg_field_h);
            end
            CMD_DRAW: predict_splat(s, it.frame);
            default: ;
        endcase
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (calm || r < 11) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one command item and predicts its effect once it is accepted.
    task automatic send_item(t_in_item it);
        int gap;
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_command(it);
        item_count++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Waits for all pixels, then lets a pending update finish.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes one register; the caller drops valid after its last write.
    task automatic write_reg(logic [2:0] idx, logic [19:0] value);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FIELD_W:  reg_field_w  = value;
            CFG_FIELD_H:  reg_field_h  = value;
            CFG_SCREEN_W: reg_screen_w = value[12:0];
            CFG_SCREEN_H: reg_screen_h = value[12:0];
            CFG_INTERP:   reg_interp   = value[0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [19:0] fw, logic [19:0] fh, logic [12:0] sw,
                             logic [12:0] sh, logic interp);
        write_reg(CFG_FIELD_W, fw);
        write_reg(CFG_FIELD_H, fh);
        write_reg(CFG_SCREEN_W, {7'd0, sw});
        write_reg(CFG_SCREEN_H, {7'd0, sh});
        write_reg(CFG_INTERP, {19'd0, interp});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item make_item(logic [1:0] cmd, logic [7:0] s,
                                           logic [19:0] lx, logic [19:0] ly,
                                           logic [7:0] shade, logic [19:0] dx,
                                           logic [19:0] dy, logic [8:0] frame);
        t_in_item it;
        it.cmd        = cmd;
        it.star       = s;
        it.load_x     = lx;
        it.load_y     = ly;
        it.load_shade = shade;
        it.delta_x    = dx;
        it.delta_y    = dy;
        it.frame      = frame;
        return it;
    endfunction

    // Edges of every field, each command, wrap both ways and a negative blend.
    task automatic test_directed();
        send_item(make_item(CMD_LOAD, 8'd0, 20'd2688, 20'd5184, 8'd224, '0, '0, '0));
        send_item(make_item(CMD_DRAW, 8'd0, '0, '0, '0, '0, '0, 9'd0));
        send_item(make_item(CMD_DRAW, 8'd0, '0, '0, '0, '0, '0, 9'd128));
        send_item(make_item(CMD_DRAW, 8'd0, '0, '0, '0, '0, '0, 9'd256));
        send_item(make_item(CMD_DRAW, 8'd0, '0, '0, '0, '0, '0, 9'd511));
        send_item(make_item(CMD_LOAD, 8'd1, 20'd0, 20'd0, 8'd0, '0, '0, '0));
        send_item(make_item(CMD_DRAW, 8'd1, '0, '0, '0, '0, '0, 9'd256));
        send_item(make_item(CMD_LOAD, 8'd255, 20'hFFFFF, 20'hFFFFF, 8'd255,
                            '0, '0, '0));
        send_item(make_item(CMD_UPDATE, 8'd255, '0, '0, '0, 20'h80000, 20'h7FFFF, '0));
        send_item(make_item(CMD_DRAW, 8'd255, '0, '0, '0, '0, '0, 9'd200));
        send_item(make_item(CMD_UPDATE, 8'd255, '0, '0, '0, 20'h7FFFF, 20'h80000, '0));
        send_item(make_item(CMD_DRAW, 8'd255, '0, '0, '0, '0, '0, 9'd256));
        send_item(make_item(2'd3, 8'd0, 20'hFFFFF, 20'hFFFFF, 8'hFF, 20'hFFFFF,
                            20'hFFFFF, 9'h1FF));
        // Wrapping down past the far edge leaves a small negative old position.
        send_item(make_item(CMD_LOAD, 8'd3, 20'd266000, 20'd171800, 8'd255,
                            '0, '0, '0));
        send_item(make_item(CMD_UPDATE, 8'd3, '0, '0, '0, -20'sd243, 20'sd234, '0));
        send_item(make_item(CMD_DRAW, 8'd3, '0, '0, '0, '0, '0, 9'd0));
        send_item(make_item(CMD_DRAW, 8'd3, '0, '0, '0, '0, '0, 9'd64));
        // Wrapping up from below zero.
        send_item(make_item(CMD_LOAD, 8'd4, 20'd100, 20'd50, 8'd128, '0, '0, '0));
        send_item(make_item(CMD_UPDATE, 8'd4, '0, '0, '0, 20'sd400, -20'sd300, '0));
        send_item(make_item(CMD_DRAW, 8'd4, '0, '0, '0, '0, '0, 9'd100));
        send_item(make_item(CMD_UPDATE, 8'd0, '0, '0, '0, 20'sd512, 20'sd512, '0));
        send_item(make_item(CMD_DRAW, 8'd0, '0, '0, '0, '0, '0, 9'd37));
    endtask

    // Random commands: mostly loaded stars in view, some noise.
    task automatic test_random(int count);
        t_in_item it;
        int       r;
        longint   span_x;
        longint   span_y;
        logic [7:0] s;
        for (int i = 0; i < count; i++) begin
            span_x = ((reg_screen_w > 4096) ? 4096 : longint'(reg_screen_w)) * 256 + 255;
            span_y = ((reg_screen_h > 4096) ? 4096 : longint'(reg_screen_h)) * 256 + 255;
            if (span_x > 20'hFFFFF) span_x = 20'hFFFFF;
            if (span_y > 20'hFFFFF) span_y = 20'hFFFFF;
            s  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 15))
                                            : 8'($urandom_range(0, 255));
            it = make_item(CMD_LOAD, s, '0, '0, '0, '0, '0, '0);
            r  = $urandom_range(0, 99);
            if (!tbl_loaded[s] || r < 20) begin
                it.cmd = CMD_LOAD;
            end else if (r < 55) begin
                it.cmd = CMD_UPDATE;
            end else if (r < 95) begin
                it.cmd = CMD_DRAW;
            end else begin
                it.cmd = 2'd3;
            end
            if ($urandom_range(0, 9) < 7) begin
                it.load_x = 20'($urandom_range(0, int'(span_x)));
                it.load_y = 20'($urandom_range(0, int'(span_y)));
            end else begin
                it.load_x = 20'($urandom);
                it.load_y = 20'($urandom);
            end
            it.load_shade = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(225, 255))
                                                         : 8'($urandom_range(0, 224));
            if ($urandom_range(0, 9) < 6) begin
                it.delta_x = 20'($signed($urandom_range(0, 8191)) - 4096);
                it.delta_y = 20'($signed($urandom_range(0, 8191)) - 4096);
            end else begin
                it.delta_x = 20'($urandom);
                it.delta_y = 20'($urandom);
            end
            it.frame = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(257, 511))
                                                   : 9'($urandom_range(0, 256));
            send_item(it);
        end
    endtask

    // Receiver stalls: short ones often, long ones rarely.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) < 3) begin
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
            end
        end
    end

    // Compares each accepted pixel with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            pixel_count++;
            if (pixel_queue.size() == 0) begin
                $error("unexpected pixel x=%0d y=%0d", o_out.pixel_x, o_out.pixel_y);
                fail_count++;
            end else begin
                want = pixel_queue.pop_front();
                if (o_out.pixel_x !== want.pixel_x) begin
                    $error("pixel_x expected %0d actual %0d", want.pixel_x, o_out.pixel_x);
                    fail_count++;
                end
                if (o_out.pixel_y !== want.pixel_y) begin
                    $error("pixel_y expected %0d actual %0d", want.pixel_y, o_out.pixel_y);
                    fail_count++;
                end
                if (o_out.intensity !== want.intensity) begin
                    $error("intensity expected %0d actual %0d",
                           want.intensity, o_out.intensity);
                    fail_count++;
                end
                if (o_out.last !== want.last) begin
                    $error("last expected %0d actual %0d", want.last, o_out.last);
                    fail_count++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d pixels outstanding", pixel_queue.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        drain();

        write_all(20'hFFFFF, 20'hFFFFF, 13'd4096, 13'd4096, 1'b0);
        test_random(50);
        drain();

        write_all(20'd1, 20'd1, 13'd1, 13'd1, 1'b1);
        calm = 1'b1;
        test_random(40);
        drain();
        calm = 1'b0;

        write_all(20'd0, 20'd0, 13'd8191, 13'd8191, 1'b1);
        test_random(40);
        drain();

        write_all(20'd204800, 20'd122880, 13'd800, 13'd480, 1'b1);
        test_random(60);
        drain();

        $display("Covered %0d command items and %0d pixels over five register settings,",
                 item_count, pixel_count);
        $display("including field and screen extremes, wraps and frames above range.");
        if (fail_count == 0 && pixel_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
